// ----- hw/rtl/ieqc_pkg.sv -----
// ----------------------------------------------------------------------------
// ieqc_pkg
// Shared types, field widths and operation codes of the input-event queue.
// ----------------------------------------------------------------------------
package ieqc_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ETYPE_W  = 5;
  localparam int WORD_W   = 32;
  localparam int COORD_W  = 20;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Default queue storage depth
  localparam int DEF_QUEUE_DEPTH = 64;

  // Register reset values
  localparam logic [CNT_W-1:0]   CAPACITY_RST = 7'd64;
  localparam logic [ETYPE_W-1:0] MOTION_RST   = 5'd8;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION   = 1'd1;

  // One accepted input transaction
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ETYPE_W-1:0]        event_type;
    logic                      injected;
    logic [WORD_W-1:0]         window_num;
    logic [WORD_W-1:0]         time_ms;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic [WORD_W-1:0]         extra_data;
  } item_t;

  // One queue entry as stored in RAM
  typedef struct packed {
    logic [ETYPE_W-1:0]        etype;
    logic [WORD_W-1:0]         window;
    logic [WORD_W-1:0]         tstamp;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] dlt_x;
    logic signed [COORD_W-1:0] dlt_y;
    logic [WORD_W-1:0]         extra;
  } entry_t;

  // One result transaction
  typedef struct packed {
    logic                      valid_res;
    logic [ETYPE_W-1:0]        out_type;
    logic [WORD_W-1:0]         out_window;
    logic [WORD_W-1:0]         out_time;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_dx;
    logic signed [COORD_W-1:0] out_dy;
    logic [WORD_W-1:0]         out_extra;
    logic                      dropped_oldest;
    logic                      merged;
    logic [CNT_W-1:0]          queue_count;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture input transaction, clear working result
    logic rd_tail;   // read newest entry
    logic rd_head;   // read oldest entry
    logic push_wr;   // append entry, drop oldest when full
    logic merge_wr;  // merge into newest entry
    logic cap_res;   // capture read entry into working result
    logic pop_adv;   // retire oldest entry
    logic fl_init;   // start flush walk
    logic fl_step;   // advance the flush walk by one step
    logic fl_end;    // commit flushed count
    logic load_out;  // move working result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              merge_cand;
    logic              empty;
    logic              merge_hit;
    logic              fl_done;
  } sts_t;

endpackage

// ----- hw/rtl/ieqc_in_if.sv -----
// ----------------------------------------------------------------------------
// ieqc_in_if
// Input channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface ieqc_in_if
  import ieqc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [ETYPE_W-1:0]        event_type;
  logic                      injected;
  logic [WORD_W-1:0]         window_num;
  logic [WORD_W-1:0]         time_ms;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] delta_x;
  logic signed [COORD_W-1:0] delta_y;
  logic [WORD_W-1:0]         extra_data;

  modport source (
    output valid, kind, event_type, injected, window_num, time_ms,
           pos_x, pos_y, delta_x, delta_y, extra_data,
    input  ready
  );

  modport sink (
    input  valid, kind, event_type, injected, window_num, time_ms,
           pos_x, pos_y, delta_x, delta_y, extra_data,
    output ready
  );
endinterface

// ----- hw/rtl/ieqc_out_if.sv -----
// ----------------------------------------------------------------------------
// ieqc_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface ieqc_out_if
  import ieqc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [ETYPE_W-1:0]        out_type;
  logic [WORD_W-1:0]         out_window;
  logic [WORD_W-1:0]         out_time;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_dx;
  logic signed [COORD_W-1:0] out_dy;
  logic [WORD_W-1:0]         out_extra;
  logic                      dropped_oldest;
  logic                      merged;
  logic [CNT_W-1:0]          queue_count;

  modport source (
    output valid, valid_res, out_type, out_window, out_time, out_x, out_y,
           out_dx, out_dy, out_extra, dropped_oldest, merged, queue_count,
    input  ready
  );

  modport sink (
    input  valid, valid_res, out_type, out_window, out_time, out_x, out_y,
           out_dx, out_dy, out_extra, dropped_oldest, merged, queue_count,
    output ready
  );
endinterface

// ----- hw/rtl/input_event_queue_coalescing_top.sv -----
// ----------------------------------------------------------------------------
// input_event_queue_coalescing_top
// Circular input-event queue with drop-oldest overflow, motion merging,
// pop/peek of the oldest entry and order-preserving flush by type.
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake              carries
//  ---------  ----  ---------------------  ---------------------------------
//  in_chan    in    valid/ready            operation and event fields
//  out_chan   out   valid/ready            returned entry, flags, count
//  cfg_*      in    cfg_we, no back-press  capacity, motion type code
//
// One transaction at a time. Push takes 3 cycles from accept to result
// (4 when the newest entry must be read for a merge check), pop and peek
// take 4 (one registered RAM read), flush takes count + 5 cycles (4 on an
// empty queue): the walk reads one entry per RAM port cycle and compacts
// survivors behind it.
// The result sits in an output register; when it is not taken the
// sequencer holds in its final state. Reset clears pointers and count;
// entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module input_event_queue_coalescing_top
  import ieqc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ieqc_in_if.sink               in_chan,
  ieqc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t in_item;
  cmd_t  cmd;
  sts_t  sts;
  res_t  res;

  // Gather input payload
  assign in_item.kind       = in_chan.kind;
  assign in_item.event_type = in_chan.event_type;
  assign in_item.injected   = in_chan.injected;
  assign in_item.window_num = in_chan.window_num;
  assign in_item.time_ms    = in_chan.time_ms;
  assign in_item.pos_x      = in_chan.pos_x;
  assign in_item.pos_y      = in_chan.pos_y;
  assign in_item.delta_x    = in_chan.delta_x;
  assign in_item.delta_y    = in_chan.delta_y;
  assign in_item.extra_data = in_chan.extra_data;

  ieqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ieqc_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

  // Scatter result payload
  assign out_chan.valid_res      = res.valid_res;
  assign out_chan.out_type       = res.out_type;
  assign out_chan.out_window     = res.out_window;
  assign out_chan.out_time       = res.out_time;
  assign out_chan.out_x          = res.out_x;
  assign out_chan.out_y          = res.out_y;
  assign out_chan.out_dx         = res.out_dx;
  assign out_chan.out_dy         = res.out_dy;
  assign out_chan.out_extra      = res.out_extra;
  assign out_chan.dropped_oldest = res.dropped_oldest;
  assign out_chan.merged         = res.merged;
  assign out_chan.queue_count    = res.queue_count;

endmodule

// ----- hw/rtl/ieqc_ram.sv -----
// ----------------------------------------------------------------------------
// ieqc_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ieqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ieqc_datapath.sv -----
// ----------------------------------------------------------------------------
// ieqc_datapath
// Queue pointers, entry RAM, merge arithmetic, flush walk and result
// registers. Acts on commands from the controller and on register writes.
// ----------------------------------------------------------------------------
module ieqc_datapath
  import ieqc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  item_t                 in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output res_t                  res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  // index arithmetic width: holds a sum of two indexes below capacity
  localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  // Configuration and pointer state
  logic [CNT_W-1:0]   capacity_r, capacity_nxt;
  logic [ETYPE_W-1:0] motion_r, motion_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Flush walk state
  logic [CNT_W-1:0] fl_i_r, fl_i_nxt;
  logic [CNT_W-1:0] fl_w_r, fl_w_nxt;
  logic             fl_pend_r, fl_pend_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [AW-1:0]    dp_r, dp_nxt;

  // Payload registers
  item_t item_r;
  res_t  wres_r, wres_nxt;
  res_t  out_r, out_nxt;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic [XW-1:0] cap_ext, cap_eff, head_x, cnt_x;
  logic [XW-1:0] tail_x, ins_x, head_adv, rp_adv, dp_adv;
  logic          full, fl_issue, fl_keep;
  entry_t        new_entry, merged_entry;

  // Add once and fold back below capacity
  function automatic logic [XW-1:0] wrap(input logic [XW-1:0] sum,
                                         input logic [XW-1:0] cap);
    logic [XW-1:0] r;
    r = (sum >= cap) ? (sum - cap) : sum;
    return r;
  endfunction

  // Signed add that clips to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    logic signed [COORD_W-1:0] r;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  // Effective capacity, clamped to 1..QUEUE_DEPTH
  assign cap_ext = XW'(capacity_r);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = XW'(1);
    end else if (cap_ext > XW'(QUEUE_DEPTH)) begin
      cap_eff = XW'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Index arithmetic
  assign head_x   = XW'(head_r);
  assign cnt_x    = XW'(count_r);
  assign full     = (cnt_x >= cap_eff);
  assign head_adv = wrap(head_x + XW'(1), cap_eff);
  assign tail_x   = wrap(head_x + cnt_x - XW'(1), cap_eff);
  // a full queue reuses the oldest slot
  assign ins_x    = full ? head_x : wrap(head_x + cnt_x, cap_eff);
  assign rp_adv   = wrap(XW'(rp_r) + XW'(1), cap_eff);
  assign dp_adv   = wrap(XW'(dp_r) + XW'(1), cap_eff);

  // Flush walk: read one entry per cycle, compact survivors in the cycle after
  assign fl_issue = (fl_i_r != count_r);
  assign fl_keep  = fl_pend_r && (ram_rdata.etype != item_r.event_type);

  // Entry images
  always_comb begin
    new_entry.etype  = item_r.event_type;
    new_entry.window = item_r.window_num;
    new_entry.tstamp = item_r.time_ms;
    new_entry.pos_x  = item_r.pos_x;
    new_entry.pos_y  = item_r.pos_y;
    new_entry.dlt_x  = item_r.delta_x;
    new_entry.dlt_y  = item_r.delta_y;
    new_entry.extra  = item_r.extra_data;

    merged_entry        = ram_rdata;
    merged_entry.tstamp = item_r.time_ms;
    merged_entry.pos_x  = item_r.pos_x;
    merged_entry.pos_y  = item_r.pos_y;
    merged_entry.dlt_x  = sat_add(ram_rdata.dlt_x, item_r.delta_x);
    merged_entry.dlt_y  = sat_add(ram_rdata.dlt_y, item_r.delta_y);
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_entry;
    if (cmd.push_wr) begin
      ram_we    = 1'b1;
      ram_waddr = ins_x[AW-1:0];
    end else if (cmd.merge_wr) begin
      ram_we    = 1'b1;
      ram_waddr = tail_x[AW-1:0];
      ram_wdata = merged_entry;
    end else if (cmd.fl_step && fl_keep) begin
      ram_we    = 1'b1;
      ram_waddr = dp_r;
      ram_wdata = ram_rdata;
    end

    ram_re    = cmd.rd_tail | cmd.rd_head | (cmd.fl_step & fl_issue);
    ram_raddr = rp_r;
    if (cmd.rd_tail) begin
      ram_raddr = tail_x[AW-1:0];
    end else if (cmd.rd_head) begin
      ram_raddr = head_r;
    end
  end

  ieqc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state of pointers, registers and flush walk
  always_comb begin
    capacity_nxt = capacity_r;
    motion_nxt   = motion_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    fl_i_nxt     = fl_i_r;
    fl_w_nxt     = fl_w_r;
    fl_pend_nxt  = fl_pend_r;
    rp_nxt       = rp_r;
    dp_nxt       = dp_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: begin
          capacity_nxt = cfg_data[CNT_W-1:0];
          head_nxt     = '0;
          count_nxt    = '0;
        end
        CFG_MOTION: begin
          motion_nxt = cfg_data[ETYPE_W-1:0];
        end
        default: begin
        end
      endcase
    end

    if (cmd.push_wr) begin
      if (full) begin
        head_nxt = head_adv[AW-1:0];
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.pop_adv) begin
      head_nxt  = head_adv[AW-1:0];
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd.fl_init) begin
      fl_i_nxt    = '0;
      fl_w_nxt    = '0;
      fl_pend_nxt = 1'b0;
      rp_nxt      = head_r;
      dp_nxt      = head_r;
    end

    if (cmd.fl_step) begin
      fl_pend_nxt = fl_issue;
      if (fl_issue) begin
        fl_i_nxt = fl_i_r + CNT_W'(1);
        rp_nxt   = rp_adv[AW-1:0];
      end
      if (fl_keep) begin
        fl_w_nxt = fl_w_r + CNT_W'(1);
        dp_nxt   = dp_adv[AW-1:0];
      end
    end

    if (cmd.fl_end) begin
      count_nxt = fl_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
      motion_r   <= MOTION_RST;
      head_r     <= '0;
      count_r    <= '0;
      fl_i_r     <= '0;
      fl_w_r     <= '0;
      fl_pend_r  <= 1'b0;
      rp_r       <= '0;
      dp_r       <= '0;
    end else begin
      capacity_r <= capacity_nxt;
      motion_r   <= motion_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      fl_i_r     <= fl_i_nxt;
      fl_w_r     <= fl_w_nxt;
      fl_pend_r  <= fl_pend_nxt;
      rp_r       <= rp_nxt;
      dp_r       <= dp_nxt;
    end
  end

  // Working result: cleared at capture, filled in as the operation runs
  always_comb begin
    wres_nxt = wres_r;
    if (cmd.latch) begin
      wres_nxt = '0;
    end else begin
      if (cmd.cap_res) begin
        wres_nxt.valid_res  = 1'b1;
        wres_nxt.out_type   = ram_rdata.etype;
        wres_nxt.out_window = ram_rdata.window;
        wres_nxt.out_time   = ram_rdata.tstamp;
        wres_nxt.out_x      = ram_rdata.pos_x;
        wres_nxt.out_y      = ram_rdata.pos_y;
        wres_nxt.out_dx     = ram_rdata.dlt_x;
        wres_nxt.out_dy     = ram_rdata.dlt_y;
        wres_nxt.out_extra  = ram_rdata.extra;
      end
      if (cmd.push_wr && full) begin
        wres_nxt.dropped_oldest = 1'b1;
      end
      if (cmd.merge_wr) begin
        wres_nxt.merged = 1'b1;
      end
    end
  end

  // Input capture and working result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    wres_r <= wres_nxt;
  end

  // Output register, with the count after the operation
  always_comb begin
    out_nxt             = wres_r;
    out_nxt.queue_count = count_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign res = out_r;

  // Status to controller
  assign sts.kind       = item_r.kind;
  assign sts.merge_cand = !item_r.injected && (item_r.event_type == motion_r)
                          && (count_r != '0);
  assign sts.empty      = (count_r == '0);
  assign sts.merge_hit  = (ram_rdata.etype == motion_r)
                          && (ram_rdata.window == item_r.window_num);
  assign sts.fl_done    = !fl_issue && !fl_pend_r;

endmodule

// ----- hw/rtl/ieqc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ieqc_ctrl
// Operation sequencer: decodes the captured transaction, steps the
// datapath through reads, writes and the flush walk, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module ieqc_ctrl
  import ieqc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_PUSH: begin
            if (sts.merge_cand) begin
              cmd.rd_tail = 1'b1;
              state_nxt   = S_MERGE;
            end else begin
              cmd.push_wr = 1'b1;
              state_nxt   = S_DONE;
            end
          end
          KIND_POP, KIND_PEEK: begin
            if (sts.empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_READ;
            end
          end
          KIND_FLUSH: begin
            cmd.fl_init = 1'b1;
            state_nxt   = S_FLUSH;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MERGE: begin
        // newest entry is back from RAM: merge or append
        if (sts.merge_hit) begin
          cmd.merge_wr = 1'b1;
        end else begin
          cmd.push_wr = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.cap_res = 1'b1;
        cmd.pop_adv = (sts.kind == KIND_POP);
        state_nxt   = S_DONE;
      end
      S_FLUSH: begin
        if (sts.fl_done) begin
          cmd.fl_end = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.fl_step = 1'b1;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- dv/input_event_queue_coalescing_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// input_event_queue_coalescing_top_tb
// Self-checking bench for the input-event queue. A shadow queue in the bench
// tracks entries, head and count. It predicts every push, pop, peek and flush
// transaction: drop-oldest, motion merging with saturating deltas, and
// order-preserving flush. The bench compares each result field by field,
// under random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module input_event_queue_coalescing_top_tb;
  import ieqc_pkg::*;

  localparam int DEPTH        = DEF_QUEUE_DEPTH;
  localparam int SETTLE_CYCLES = 100;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ieqc_in_if  in_chan ();
  ieqc_out_if out_chan ();

  input_event_queue_coalescing_top #(
    .QUEUE_DEPTH (DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the queue and its registers
  entry_t             shadow_entries [DEPTH];
  int unsigned        shadow_head;
  int unsigned        shadow_count;
  logic [CNT_W-1:0]   shadow_capacity;
  logic [ETYPE_W-1:0] shadow_motion;

  res_t               pending_results [$];
  int                 error_count = 0;
  bit                 src_gaps_en;
  bit                 sink_stall_en;
  int                 sink_holdoff_cycles;
  logic [WORD_W-1:0]  window_pool [4];

  // Saturating Q16.4 delta sum
  function automatic logic signed [COORD_W-1:0] sat_delta_sum(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    int s;
    s = int'(a) + int'(b);
    if (s > int'(COORD_MAX)) begin
      s = int'(COORD_MAX);
    end else if (s < int'(COORD_MIN)) begin
      s = int'(COORD_MIN);
    end
    return s[COORD_W-1:0];
  endfunction

  // Apply one transaction to the shadow queue and return its result
  function automatic res_t predict_queue_op(input item_t op);
    res_t        r;
    int unsigned cap;
    int unsigned tail;
    int unsigned rd;
    int unsigned wr;
    bit          merge_done;
    r          = '0;
    merge_done = 1'b0;
    if (shadow_capacity == 0) begin
      cap = 1;
    end else if (shadow_capacity > DEPTH) begin
      cap = DEPTH;
    end else begin
      cap = 32'(shadow_capacity);
    end
    if (shadow_count > cap) shadow_count = cap;
    shadow_head = shadow_head % cap;

    case (op.kind)
      KIND_PUSH: begin
        // merge into the newest motion entry of the same window
        if (!op.injected && op.event_type == shadow_motion && shadow_count > 0) begin
          tail = (shadow_head + shadow_count - 1) % cap;
          if (shadow_entries[tail].etype == shadow_motion &&
              shadow_entries[tail].window == op.window_num) begin
            shadow_entries[tail].dlt_x  = sat_delta_sum(shadow_entries[tail].dlt_x, op.delta_x);
            shadow_entries[tail].dlt_y  = sat_delta_sum(shadow_entries[tail].dlt_y, op.delta_y);
            shadow_entries[tail].pos_x  = op.pos_x;
            shadow_entries[tail].pos_y  = op.pos_y;
            shadow_entries[tail].tstamp = op.time_ms;
            r.merged   = 1'b1;
            merge_done = 1'b1;
          end
        end
        // append, dropping the oldest when full
        if (!merge_done) begin
          if (shadow_count >= cap) begin
            shadow_head      = (shadow_head + 1) % cap;
            shadow_count     = cap - 1;
            r.dropped_oldest = 1'b1;
          end
          wr = (shadow_head + shadow_count) % cap;
          shadow_entries[wr] = '{etype: op.event_type, window: op.window_num,
                                 tstamp: op.time_ms, pos_x: op.pos_x, pos_y: op.pos_y,
                                 dlt_x: op.delta_x, dlt_y: op.delta_y,
                                 extra: op.extra_data};
          shadow_count++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (shadow_count > 0) begin
          r.valid_res  = 1'b1;
          r.out_type   = shadow_entries[shadow_head].etype;
          r.out_window = shadow_entries[shadow_head].window;
          r.out_time   = shadow_entries[shadow_head].tstamp;
          r.out_x      = shadow_entries[shadow_head].pos_x;
          r.out_y      = shadow_entries[shadow_head].pos_y;
          r.out_dx     = shadow_entries[shadow_head].dlt_x;
          r.out_dy     = shadow_entries[shadow_head].dlt_y;
          r.out_extra  = shadow_entries[shadow_head].extra;
          if (op.kind == KIND_POP) begin
            shadow_head = (shadow_head + 1) % cap;
            shadow_count--;
          end
        end
      end
      KIND_FLUSH: begin
        // compact survivors toward the head, order kept
        wr = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          rd = (shadow_head + i) % cap;
          if (shadow_entries[rd].etype != op.event_type) begin
            shadow_entries[(shadow_head + wr) % cap] = shadow_entries[rd];
            wr++;
          end
        end
        shadow_count = wr;
      end
      default: ;
    endcase
    r.queue_count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic item_t build_op(
    input logic [KIND_W-1:0]         kind,
    input logic [ETYPE_W-1:0]        etype,
    input logic                      inj,
    input logic [WORD_W-1:0]         win,
    input logic [WORD_W-1:0]         tm,
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py,
    input logic signed [COORD_W-1:0] dx,
    input logic signed [COORD_W-1:0] dy,
    input logic [WORD_W-1:0]         extra
  );
    item_t op;
    op.kind       = kind;
    op.event_type = etype;
    op.injected   = inj;
    op.window_num = win;
    op.time_ms    = tm;
    op.pos_x      = px;
    op.pos_y      = py;
    op.delta_x    = dx;
    op.delta_y    = dy;
    op.extra_data = extra;
    return op;
  endfunction

  // Deltas lean on the extremes so that merges saturate often
  function automatic logic signed [COORD_W-1:0] random_delta();
    case ($urandom_range(0, 3))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
    endcase
  endfunction

  // Mostly motion traffic on a few windows, so merges, drops and flushes hit
  function automatic item_t random_op();
    item_t       op;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      op.kind = KIND_PUSH;
    end else if (sel < 75) begin
      op.kind = KIND_POP;
    end else if (sel < 88) begin
      op.kind = KIND_PEEK;
    end else begin
      op.kind = KIND_FLUSH;
    end
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      op.event_type = shadow_motion;
    end else if (sel < 8) begin
      op.event_type = shadow_motion ^ ETYPE_W'(1);
    end else begin
      op.event_type = ETYPE_W'($urandom);
    end
    op.injected   = ($urandom_range(0, 4) == 0);
    op.window_num = ($urandom_range(0, 7) == 0) ? WORD_W'($urandom)
                                                : window_pool[$urandom_range(0, 3)];
    op.time_ms    = $urandom;
    op.pos_x      = COORD_W'($urandom);
    op.pos_y      = COORD_W'($urandom);
    op.delta_x    = random_delta();
    op.delta_y    = random_delta();
    op.extra_data = $urandom;
    return op;
  endfunction

  // Offer one transaction, wait for acceptance, record its prediction.
  // valid stays high after acceptance; the next call may lower it for a gap, a drain lowers it.
  task automatic send_event(input item_t op);
    if (src_gaps_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= op.kind;
    in_chan.event_type <= op.event_type;
    in_chan.injected   <= op.injected;
    in_chan.window_num <= op.window_num;
    in_chan.time_ms    <= op.time_ms;
    in_chan.pos_x      <= op.pos_x;
    in_chan.pos_y      <= op.pos_y;
    in_chan.delta_x    <= op.delta_x;
    in_chan.delta_y    <= op.delta_y;
    in_chan.extra_data <= op.extra_data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(predict_queue_op(op));
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; the block is idle whenever this is called
  task automatic write_register(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] value
  );
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) begin
      // capacity write empties the queue
      shadow_capacity = value;
      shadow_head     = 0;
      shadow_count    = 0;
    end else begin
      shadow_motion = value[ETYPE_W-1:0];
    end
    @(posedge clk);
  endtask

  // Empty queue, merge chain with saturation, injected bypass, flush
  task automatic test_directed_ops();
    logic [WORD_W-1:0] w;
    w = 32'h0000_0011;
    send_event(build_op(KIND_POP,   5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_PEEK,  5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_FLUSH, MOTION_RST, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, w, '1, COORD_MAX, COORD_MIN,
                        COORD_MAX, COORD_MIN, '1));
    // deltas saturate in both directions
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, w, 32'd5, COORD_MIN, COORD_MAX,
                        COORD_MAX, COORD_MIN, 32'hdead_beef));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b1, w, 32'd6, 20'sd3, 20'sd4,
                        20'sd5, -20'sd6, 32'h1234_5678));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, w, 32'd7, -20'sd1, 20'sd1,
                        -20'sd9, 20'sd9, '0));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, '1, 32'd8, 20'sd10, 20'sd11,
                        20'sd12, 20'sd13, 32'h5555_aaaa));
    send_event(build_op(KIND_PUSH, 5'd31, 1'b0, '0, '0, '0, '0, COORD_MIN, COORD_MAX, '0));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, '1, 32'd9, 20'sd1, 20'sd2,
                        20'sd3, 20'sd4, 32'haaaa_5555));
    send_event(build_op(KIND_PEEK,  5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_POP,   5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_FLUSH, MOTION_RST, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    // flush of an absent type leaves the queue alone
    send_event(build_op(KIND_FLUSH, 5'd5, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_POP,   5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_POP,   5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_PUSH,  5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_PUSH,  5'd1, 1'b1, '1, '1, '1, '1, '1, '1, '1));
    send_event(build_op(KIND_FLUSH, 5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_PEEK,  5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    drain_results();
  endtask

  // Capacity extremes, overflow with drop, merge into a full queue,
  // motion code changes
  task automatic test_capacity_limits();
    item_t op;
    write_register(CFG_CAPACITY, 7'd1);
    send_event(build_op(KIND_PUSH, 5'd3, 1'b0, 32'd1, 32'd1, '0, '0, '0, '0, 32'd1));
    send_event(build_op(KIND_PUSH, 5'd4, 1'b0, 32'd2, 32'd2, '0, '0, '0, '0, 32'd2));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, 32'd7, 32'd3, 20'sd1, 20'sd1,
                        20'sd100, -20'sd100, 32'd3));
    send_event(build_op(KIND_PUSH, MOTION_RST, 1'b0, 32'd7, 32'd4, 20'sd2, 20'sd2,
                        20'sd23, -20'sd23, 32'd4));
    send_event(build_op(KIND_PEEK, 5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_event(build_op(KIND_POP,  5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    drain_results();

    // zero acts as a capacity of one
    write_register(CFG_CAPACITY, 7'd0);
    for (int n = 0; n < 3; n++) begin
      op = random_op();
      op.kind = KIND_PUSH;
      send_event(op);
    end
    send_event(build_op(KIND_POP, 5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    drain_results();

    // above the storage depth: clamps, then overflow the full depth
    write_register(CFG_CAPACITY, 7'd127);
    for (int n = 0; n < DEPTH + 3; n++) begin
      op = random_op();
      op.kind     = KIND_PUSH;
      op.injected = 1'b1;
      send_event(op);
    end
    send_event(build_op(KIND_FLUSH, shadow_motion, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    for (int n = 0; n < 3; n++) begin
      send_event(build_op(KIND_POP, 5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    end
    drain_results();

    // motion code extremes, upper data bits set
    write_register(CFG_MOTION, 7'h7f);
    send_event(build_op(KIND_PUSH, 5'd31, 1'b0, 32'd9, 32'd1, 20'sd1, 20'sd1,
                        20'sd1, 20'sd1, '0));
    send_event(build_op(KIND_PUSH, 5'd31, 1'b0, 32'd9, 32'd2, 20'sd2, 20'sd2,
                        20'sd2, 20'sd2, '1));
    drain_results();
    write_register(CFG_MOTION, 7'h60);
    send_event(build_op(KIND_PUSH, 5'd0, 1'b0, 32'd9, 32'd3, 20'sd3, 20'sd3,
                        20'sd3, 20'sd3, '0));
    send_event(build_op(KIND_PUSH, 5'd0, 1'b0, 32'd9, 32'd4, 20'sd4, 20'sd4,
                        COORD_MIN, COORD_MIN, '1));
    send_event(build_op(KIND_POP, 5'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    drain_results();
  endtask

  // Result side holds off while pushes keep coming, then the source
  // pauses until everything is back
  task automatic test_backpressure();
    item_t op;
    write_register(CFG_CAPACITY, 7'd64);
    write_register(CFG_MOTION, {2'b00, MOTION_RST});
    src_gaps_en         = 1'b0;
    sink_holdoff_cycles = 60;
    for (int n = 0; n < 12; n++) begin
      op = random_op();
      if (n % 3 != 2) op.kind = KIND_PUSH;
      send_event(op);
    end
    drain_results();
    src_gaps_en = 1'b1;
  endtask

  // Random traffic over several capacity and motion settings
  task automatic test_random_traffic();
    logic [CNT_W-1:0]   caps    [8];
    logic [ETYPE_W-1:0] motions [8];
    caps    = '{7'd1, 7'd2, 7'd0, 7'd5, 7'd64, 7'd127, 7'd3, 7'd16};
    motions = '{MOTION_RST, 5'd0, 5'd31, 5'd8, 5'd0, 5'd31, 5'd8, 5'd0};
    caps[7]    = CNT_W'($urandom_range(4, 63));
    motions[7] = ETYPE_W'($urandom);
    for (int ph = 0; ph < 8; ph++) begin
      write_register(CFG_CAPACITY, caps[ph]);
      write_register(CFG_MOTION, {2'($urandom), motions[ph]});
      window_pool[0] = '0;
      window_pool[1] = '1;
      window_pool[2] = $urandom;
      window_pool[3] = $urandom;
      // no idling in the closing phases
      src_gaps_en   = (ph < 6);
      sink_stall_en = (ph < 6);
      for (int n = 0; n < 100; n++) begin
        send_event(random_op());
      end
      drain_results();
    end
  endtask

  // Result ready: random stalls, plus a requested long hold-off
  initial begin : result_ready_gen
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_holdoff_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (sink_holdoff_cycles) @(posedge clk);
        sink_holdoff_cycles = 0;
        out_chan.ready <= 1'b1;
      end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(
    input string             name,
    input logic [WORD_W-1:0] want,
    input logic [WORD_W-1:0] got
  );
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("valid_res", WORD_W'(want.valid_res),
                    WORD_W'(out_chan.valid_res));
        check_field("out_type", WORD_W'(want.out_type),
                    WORD_W'(out_chan.out_type));
        check_field("out_window", want.out_window, out_chan.out_window);
        check_field("out_time", want.out_time, out_chan.out_time);
        check_field("out_x", WORD_W'(want.out_x), WORD_W'(out_chan.out_x));
        check_field("out_y", WORD_W'(want.out_y), WORD_W'(out_chan.out_y));
        check_field("out_dx", WORD_W'(want.out_dx), WORD_W'(out_chan.out_dx));
        check_field("out_dy", WORD_W'(want.out_dy), WORD_W'(out_chan.out_dy));
        check_field("out_extra", want.out_extra, out_chan.out_extra);
        check_field("dropped_oldest", WORD_W'(want.dropped_oldest),
                    WORD_W'(out_chan.dropped_oldest));
        check_field("merged", WORD_W'(want.merged), WORD_W'(out_chan.merged));
        check_field("queue_count", WORD_W'(want.queue_count),
                    WORD_W'(out_chan.queue_count));
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_CAPACITY;
    cfg_data           = '0;
    in_chan.valid      = 1'b0;
    in_chan.kind       = KIND_PUSH;
    in_chan.event_type = '0;
    in_chan.injected   = 1'b0;
    in_chan.window_num = '0;
    in_chan.time_ms    = '0;
    in_chan.pos_x      = '0;
    in_chan.pos_y      = '0;
    in_chan.delta_x    = '0;
    in_chan.delta_y    = '0;
    in_chan.extra_data = '0;
    shadow_capacity     = CAPACITY_RST;
    shadow_motion       = MOTION_RST;
    shadow_head         = 0;
    shadow_count        = 0;
    src_gaps_en         = 1'b1;
    sink_stall_en       = 1'b1;
    sink_holdoff_cycles = 0;
    window_pool         = '{32'd0, '1, 32'h11, 32'h22};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("input_event_queue_coalescing_top_tb OK");
    end else begin
      $display("input_event_queue_coalescing_top_tb NOT OK");
    end
    $finish;
  end

  // Hang guard
  initial begin : run_limit
    #5ms;
    $display("input_event_queue_coalescing_top_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ieqc_pkg.sv
hw/rtl/ieqc_in_if.sv
hw/rtl/ieqc_out_if.sv
hw/rtl/ieqc_ram.sv
hw/rtl/ieqc_datapath.sv
hw/rtl/ieqc_ctrl.sv
hw/rtl/input_event_queue_coalescing_top.sv
dv/input_event_queue_coalescing_top_tb.sv
